// ===== sv/grm_pkg.sv =====
package grm_pkg;

   // Grid geometry
   localparam int unsigned GRID_SIDE  = 8;
   localparam int unsigned GRID_TILES = GRID_SIDE * GRID_SIDE;
   localparam int unsigned COORD_W    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
   localparam int unsigned IDX_W      = (GRID_TILES > 1) ? $clog2(GRID_TILES) : 1;
   localparam int unsigned SPAN_W     = $clog2(GRID_SIDE + 1);
   localparam int unsigned AREA_W     = $clog2(GRID_TILES + 1);

   // Field widths
   localparam int unsigned COLOR_W    = 32;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned SIZE_W     = 13;
   localparam int unsigned TP_W       = 7;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_PIXELS = 2'd2;

   typedef logic [COLOR_W-1:0]       color_type;
   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic [SIZE_W-1:0]        size_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SPAN,
      ST_GROW,
      ST_EMIT,
      ST_MARK
   } merge_state_type;

endpackage

// ===== sv/grm_ifs.sv =====
interface grm_req_if;
   import grm_pkg::*;

   logic      valid;
   logic      ready;
   color_type tile_color;

   modport source (output valid, output tile_color, input ready);
   modport sink   (input valid, input tile_color, output ready);
endinterface

interface grm_rsp_if;
   import grm_pkg::*;

   logic      valid;
   logic      ready;
   pos_type   rect_x;
   pos_type   rect_y;
   size_type  rect_width_px;
   size_type  rect_height_px;
   color_type rect_color;
   logic      last_rect;

   modport source (output valid, output rect_x, output rect_y, output rect_width_px,
                   output rect_height_px, output rect_color, output last_rect,
                   input ready);
   modport sink   (input valid, input rect_x, input rect_y, input rect_width_px,
                   input rect_height_px, input rect_color, input last_rect,
                   output ready);
endinterface

// ===== sv/grm_ram.sv =====
module grm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/greedy_rectangle_merge.sv =====
// Greedy rectangle merge. Load a GRID_SIDE x GRID_SIDE grid of tile colors, one item
// per cycle in raster order, into the color memory. The item that completes the grid starts
// the merge: the grid is scanned in raster order, and at each uncovered tile the run of equal,
// uncovered color to the right is measured, then grown downward row by row (the width is cut at
// the first mismatch in each row) and the largest-area rectangle is kept, the earliest on a tie.
// Each rectangle leaves as one item with world pixel origin, pixel size and color; last_rect
// marks the final one of the chunk. No input is taken while a merge runs. The covered map sits
// in a second, one-bit memory read at the same address as the colors; each loaded tile clears
// its covered bit, so no separate clearing pass is needed. The merge spends a scan step on each
// already covered anchor and, per rectangle, a step to fetch the anchor, a probe per tile along
// the first row and down the growing rows, an emit step that waits while the output is stalled,
// and then a marking step per tile of the rectangle (the final rectangle skips the marking). All
// of this is paced by the single read port of the memories, one probe per cycle. Register
// writes (origin_x, origin_y, tile_pixels) are applied as they come; a tile_pixels of zero is
// used as one.
module greedy_rectangle_merge (
   input  logic                          clock,
   input  logic                          reset,
   grm_req_if.sink                       req_bus,
   grm_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [grm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [grm_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import grm_pkg::*;

   function automatic logic [IDX_W-1:0] tile_index(input int unsigned r, input int unsigned c);
      return IDX_W'(r * GRID_SIDE + c);
   endfunction

   // Control state
   merge_state_type state_ff, state_in;
   logic [IDX_W-1:0]      load_count_ff, load_count_in;
   logic [COORD_W-1:0]    row_ff, row_in;
   logic [COORD_W-1:0]    col_ff, col_in;
   logic [SPAN_W-1:0]     w_ff, w_in;
   logic [SPAN_W-1:0]     h_ff, h_in;
   logic [SPAN_W-1:0]     span_ff, span_in;
   logic [SPAN_W-1:0]     best_w_ff, best_w_in;
   logic [SPAN_W-1:0]     best_h_ff, best_h_in;
   logic [AREA_W-1:0]     best_area_ff, best_area_in;
   logic [AREA_W-1:0]     covered_count_ff, covered_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   color_type             color_ff, color_in;
   logic [POS_W-1:0]      rect_x_ff, rect_y_ff;
   size_type              rect_w_ff, rect_h_ff;
   color_type             rect_color_ff;
   logic                  rect_last_ff;

   // Configuration registers
   logic [POS_W-1:0]      origin_x_ff, origin_y_ff;
   logic [TP_W-1:0]       tile_pixels_ff;

   // Memory ports
   logic [IDX_W-1:0]      rd_addr;
   color_type             rd_data;
   logic                  req_accept;
   logic                  cov_wr_en;
   logic [IDX_W-1:0]      cov_wr_addr;
   logic [0:0]            cov_wr_data;
   logic [0:0]            cov_rd_data;

   // Probe evaluation
   logic [SPAN_W:0]       probe_row_wide, probe_col_wide;
   logic [IDX_W-1:0]      probe_idx;
   color_type             color_cur;
   logic                  tile_free;
   logic                  span_done;
   logic [SPAN_W-1:0]     span_len;
   logic [SPAN_W-1:0]     eff_span;
   logic                  row_done, grow_stop;
   logic [SPAN_W-1:0]     h_next;
   logic [2*SPAN_W-1:0]   area_next;
   logic                  area_better;
   logic                  row_last, col_last, probe_row_last;

   // Emission
   logic                  emit_fire;
   logic [AREA_W:0]       covered_sum;
   logic                  rect_last_in;
   logic [TP_W-1:0]       tp_eff;
   logic [COORD_W+TP_W-1:0] col_px, row_px;
   logic [SPAN_W+TP_W-1:0]  w_px, h_px;

   grm_ram #(.WIDTH(COLOR_W), .DEPTH(GRID_TILES)) u_color_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (load_count_ff),
      .wr_data (req_bus.tile_color),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Clear each covered bit as its tile loads; set it while marking a rectangle
   grm_ram #(.WIDTH(1), .DEPTH(GRID_TILES)) u_covered_ram (
      .clock   (clock),
      .wr_en   (cov_wr_en),
      .wr_addr (cov_wr_addr),
      .wr_data (cov_wr_data),
      .rd_addr (rd_addr),
      .rd_data (cov_rd_data)
   );

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign cov_wr_en      = req_accept || (state_ff == ST_MARK);
   assign cov_wr_addr    = (state_ff == ST_MARK) ? probe_idx : load_count_ff;
   assign cov_wr_data[0] = (state_ff == ST_MARK);

   // Read address follows the next probe position so the data lines up with it in the next cycle
   assign rd_addr = tile_index(int'(row_in) + int'(h_in), int'(col_in) + int'(w_in));

   assign probe_row_wide = (SPAN_W+1)'(row_ff) + (SPAN_W+1)'(h_ff);
   assign probe_col_wide = (SPAN_W+1)'(col_ff) + (SPAN_W+1)'(w_ff);
   assign probe_idx      = tile_index(int'(probe_row_wide), int'(probe_col_wide));

   assign row_last       = (row_ff == COORD_W'(GRID_SIDE - 1));
   assign col_last       = (col_ff == COORD_W'(GRID_SIDE - 1));
   assign probe_row_last = (probe_row_wide == (SPAN_W+1)'(GRID_SIDE - 1));

   // The anchor's own color arrives on the first span probe
   assign color_cur = (state_ff == ST_SPAN && w_ff == '0) ? rd_data : color_ff;
   assign tile_free = (rd_data == color_cur) && !cov_rd_data[0];

   // First row: stop at the first mismatch or at the right edge
   always_comb begin
      span_done = 1'b0;
      span_len  = w_ff;
      if (tile_free) begin
         if (probe_col_wide == (SPAN_W+1)'(GRID_SIDE - 1)) begin
            span_done = 1'b1;
            span_len  = w_ff + SPAN_W'(1);
         end
      end else begin
         span_done = 1'b1;
      end
   end

   // Growing rows: a mismatch cuts the width to the tiles matched so far
   assign eff_span    = tile_free ? span_ff : w_ff;
   assign row_done    = tile_free ? (w_ff + SPAN_W'(1) == span_ff) : (w_ff != '0);
   assign grow_stop   = !tile_free && (w_ff == '0);
   assign h_next      = h_ff + SPAN_W'(1);
   assign area_next   = (2*SPAN_W)'(eff_span) * (2*SPAN_W)'(h_next);
   assign area_better = area_next > (2*SPAN_W)'(best_area_ff);

   // The chunk ends once the covered tiles add up to the whole grid
   assign covered_sum  = (AREA_W+1)'(covered_count_ff) + (AREA_W+1)'(best_area_ff);
   assign rect_last_in = (covered_sum == (AREA_W+1)'(GRID_TILES));
   assign emit_fire    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   assign tp_eff = (tile_pixels_ff == '0) ? TP_W'(1) : tile_pixels_ff;
   assign col_px = (COORD_W+TP_W)'(col_ff) * (COORD_W+TP_W)'(tp_eff);
   assign row_px = (COORD_W+TP_W)'(row_ff) * (COORD_W+TP_W)'(tp_eff);
   assign w_px   = (SPAN_W+TP_W)'(best_w_ff) * (SPAN_W+TP_W)'(tp_eff);
   assign h_px   = (SPAN_W+TP_W)'(best_h_ff) * (SPAN_W+TP_W)'(tp_eff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept && load_count_ff == IDX_W'(GRID_TILES - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!cov_rd_data[0]) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            if (span_done) begin
               state_in = row_last ? ST_EMIT : ST_GROW;
            end
         end
         ST_GROW: begin
            if (row_done) begin
               state_in = probe_row_last ? ST_EMIT : ST_GROW;
            end else if (grow_stop) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = rect_last_in ? ST_LOAD : ST_MARK;
            end
         end
         ST_MARK: begin
            if (w_ff == '0 && h_ff == '0) begin
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Datapath and counters
   always_comb begin
      load_count_in    = load_count_ff;
      row_in           = row_ff;
      col_in           = col_ff;
      w_in             = w_ff;
      h_in             = h_ff;
      span_in          = span_ff;
      best_w_in        = best_w_ff;
      best_h_in        = best_h_ff;
      best_area_in     = best_area_ff;
      covered_count_in = covered_count_ff;
      color_in         = color_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         ST_LOAD: begin
            row_in = '0;
            col_in = '0;
            w_in   = '0;
            h_in   = '0;
            if (req_accept) begin
               load_count_in = (load_count_ff == IDX_W'(GRID_TILES - 1)) ?
                               '0 : load_count_ff + IDX_W'(1);
            end
         end
         ST_SCAN: begin
            w_in = '0;
            h_in = '0;
            // skip a covered anchor; it never is the last tile of a running merge
            if (cov_rd_data[0]) begin
               if (col_last) begin
                  col_in = '0;
                  row_in = row_ff + COORD_W'(1);
               end else begin
                  col_in = col_ff + COORD_W'(1);
               end
            end
         end
         ST_SPAN: begin
            if (w_ff == '0) begin
               color_in = rd_data;
            end
            if (span_done) begin
               span_in      = span_len;
               best_w_in    = span_len;
               best_h_in    = SPAN_W'(1);
               best_area_in = AREA_W'(span_len);
               h_in         = SPAN_W'(1);
               w_in         = '0;
            end else begin
               w_in = w_ff + SPAN_W'(1);
            end
         end
         ST_GROW: begin
            if (row_done) begin
               span_in = eff_span;
               if (area_better) begin
                  best_w_in    = eff_span;
                  best_h_in    = h_next;
                  best_area_in = AREA_W'(area_next);
               end
               h_in = h_next;
               w_in = '0;
            end else if (!grow_stop) begin
               w_in = w_ff + SPAN_W'(1);
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in     = 1'b1;
               covered_count_in = rect_last_in ? '0 : covered_sum[AREA_W-1:0];
               // Mark from the far corner back to the anchor
               w_in             = best_w_ff - SPAN_W'(1);
               h_in             = best_h_ff - SPAN_W'(1);
            end
         end
         ST_MARK: begin
            // The anchor is written last, so the next anchor's read never meets a write
            // to the same entry: a tile right of the anchor was marked in an earlier cycle.
            if (w_ff == '0) begin
               if (h_ff == '0) begin
                  if (col_last) begin
                     col_in = '0;
                     row_in = row_ff + COORD_W'(1);
                  end else begin
                     col_in = col_ff + COORD_W'(1);
                  end
               end else begin
                  h_in = h_ff - SPAN_W'(1);
                  w_in = best_w_ff - SPAN_W'(1);
               end
            end else begin
               w_in = w_ff - SPAN_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_LOAD;
         load_count_ff    <= '0;
         row_ff           <= '0;
         col_ff           <= '0;
         w_ff             <= '0;
         h_ff             <= '0;
         span_ff          <= '0;
         best_w_ff        <= SPAN_W'(1);
         best_h_ff        <= SPAN_W'(1);
         best_area_ff     <= AREA_W'(1);
         covered_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         tile_pixels_ff   <= TP_W'(16);
      end else begin
         state_ff         <= state_in;
         load_count_ff    <= load_count_in;
         row_ff           <= row_in;
         col_ff           <= col_in;
         w_ff             <= w_in;
         h_ff             <= h_in;
         span_ff          <= span_in;
         best_w_ff        <= best_w_in;
         best_h_ff        <= best_h_in;
         best_area_ff     <= best_area_in;
         covered_count_ff <= covered_count_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_ORIGIN_X:    origin_x_ff    <= csr_write_data;
               CSR_ORIGIN_Y:    origin_y_ff    <= csr_write_data;
               CSR_TILE_PIXELS: tile_pixels_ff <= csr_write_data[TP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Anchor color and output item payload
   always_ff @(posedge clock) begin
      color_ff <= color_in;
      if (emit_fire) begin
         rect_x_ff     <= origin_x_ff + POS_W'(col_px);
         rect_y_ff     <= origin_y_ff + POS_W'(row_px);
         rect_w_ff     <= SIZE_W'(w_px);
         rect_h_ff     <= SIZE_W'(h_px);
         rect_color_ff <= color_ff;
         rect_last_ff  <= rect_last_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.rect_x         = rect_x_ff;
   assign rsp_bus.rect_y         = rect_y_ff;
   assign rsp_bus.rect_width_px  = rect_w_ff;
   assign rsp_bus.rect_height_px = rect_h_ff;
   assign rsp_bus.rect_color     = rect_color_ff;
   assign rsp_bus.last_rect      = rect_last_ff;

   a_load_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (covered_count_ff == '0))
      else $error("covered count not clear while loading");

   a_grow_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GROW) |-> (w_ff < span_ff && probe_row_wide < (SPAN_W+1)'(GRID_SIDE)))
      else $error("grow probe outside the rectangle or the grid");

   a_best_area: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |->
         ((2*SPAN_W)'(best_w_ff) * (2*SPAN_W)'(best_h_ff) == (2*SPAN_W)'(best_area_ff)))
      else $error("best area does not match best width and height");

   a_last_ends_merge: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && rect_last_in) |=> (state_ff == ST_LOAD && rsp_valid_ff && rect_last_ff))
      else $error("final rectangle did not return the block to loading");

   a_anchor_uncovered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !cov_rd_data[0]) |=> (state_ff == ST_SPAN && w_ff == '0))
      else $error("uncovered anchor did not start a span");

   a_mark_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (w_ff < best_w_ff && h_ff < best_h_ff))
      else $error("mark position outside the rectangle");

endmodule
